### src/ohlc_pkg.sv
package ohlc_pkg;

  // Field widths.
  localparam int TIME_W    = 40;
  localparam int PRICE_W   = 32;
  localparam int QTY_W     = 32;
  localparam int VOL_W     = 48;
  localparam int COUNT_W   = 16;
  localparam int SESSION_W = 32;
  localparam int LEN_W     = 20;

  // Configuration port.
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 20;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_TICK_MODE     = 2'd0,
    REG_BAR_LENGTH    = 2'd1,
    REG_TICKS_PER_BAR = 2'd2
  } cfg_reg_e;

  localparam logic [LEN_W-1:0]   RESET_BAR_SECONDS   = 20'd60;
  localparam logic [LEN_W-1:0]   MIN_BAR_SECONDS     = 20'd5;
  localparam logic [COUNT_W-1:0] RESET_TICKS_PER_BAR = 16'd100;

  // A day is 86400 = 128 * 675 seconds. The low seven bits of the time pass
  // straight into the time of day; the rest is reduced modulo 675.
  localparam int DAY_SHIFT = 7;
  localparam int DAY_ODD   = 675;
  localparam int DAY_REM_W = 10;
  localparam int TOD_W     = DAY_REM_W + DAY_SHIFT;
  localparam int DAYQ_W    = TIME_W - DAY_SHIFT;
  localparam int REM_W     = LEN_W;
  localparam int STEP_W    = 6;

  // The reduction modulo 675 folds the value in eleven-bit pieces, using
  // 2^11 = 23 and 2^22 = 529 modulo 675. Three folds bring any 33-bit value
  // below 2209, and a final compare and subtract finishes the job.
  localparam int DAY_FOLD_W      = 11;
  localparam int DAY_FOLD_MUL1   = 23;
  localparam int DAY_FOLD_MUL2   = 529;
  localparam int DAY_FOLD_PROD_W = 21;
  localparam int DAY_FOLDS       = 3;

  // Default queue depths.
  localparam int WORK_QUEUE_DEPTH   = 2;
  localparam int RESULT_QUEUE_DEPTH = 2;

  typedef struct packed {
    logic               mode;
    logic [TIME_W-1:0]  t;
    logic [PRICE_W-1:0] price;
    logic [QTY_W-1:0]   qty;
  } trade_t;

  typedef struct packed {
    trade_t            trade;
    logic [TIME_W-1:0] slot_start;
    logic [TIME_W-1:0] slot_end;
  } work_t;

  typedef struct packed {
    logic [TIME_W-1:0]    bar_time;
    logic [PRICE_W-1:0]   open_price;
    logic [PRICE_W-1:0]   high_price;
    logic [PRICE_W-1:0]   low_price;
    logic [PRICE_W-1:0]   close_price;
    logic [VOL_W-1:0]     volume;
    logic [COUNT_W-1:0]   tick_count;
    logic [SESSION_W-1:0] session_number;
  } bar_t;

endpackage

### src/ohlc_fifo.sv
module ohlc_fifo #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 2
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             wr_en,
  input  logic [WIDTH-1:0] wr_data,
  output logic             full,
  input  logic             rd_en,
  output logic [WIDTH-1:0] rd_data,
  output logic             empty
);

  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [PTR_W-1:0] wr_ptr;
  logic [PTR_W-1:0] rd_ptr;
  logic [CNT_W-1:0] count;
  logic             do_wr;
  logic             do_rd;

  assign full    = (count == CNT_W'(DEPTH));
  assign empty   = (count == '0);
  assign do_wr   = wr_en && !full;
  assign do_rd   = rd_en && !empty;
  assign rd_data = mem[rd_ptr];

  always_ff @(posedge clk) begin
    if (do_wr) begin
      mem[wr_ptr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_wr) begin
        wr_ptr <= (wr_ptr == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (do_rd) begin
        rd_ptr <= (rd_ptr == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      if (do_wr && !do_rd) begin
        count <= count + 1'b1;
      end else if (do_rd && !do_wr) begin
        count <= count - 1'b1;
      end
    end
  end

  a_count_in_range: assert property (@(posedge clk) disable iff (rst)
    count <= CNT_W'(DEPTH))
    else $error("queue occupancy above its depth");

  a_count_grows: assert property (@(posedge clk) disable iff (rst)
    (do_wr && !do_rd) |=> (count == $past(count) + 1'b1))
    else $error("queue occupancy did not follow a lone write");

endmodule

### src/ohlc_front.sv
module ohlc_front (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        push,
  output logic                        full,
  input  ohlc_pkg::trade_t            in_item,
  input  logic                        tick_mode,
  input  logic [ohlc_pkg::LEN_W-1:0]  len_eff,
  output logic                        q_push,
  input  logic                        q_full,
  output ohlc_pkg::work_t             q_item
);

  import ohlc_pkg::*;

  typedef enum logic [5:0] {
    S_IDLE  = 6'b000001,
    S_DAY   = 6'b000010,
    S_SLOT  = 6'b000100,
    S_START = 6'b001000,
    S_END   = 6'b010000,
    S_SEND  = 6'b100000
  } front_state_t;

  front_state_t      state;
  front_state_t      state_next;
  trade_t            item;
  logic [TIME_W-1:0] slot_start;
  logic [TIME_W-1:0] slot_end;
  logic [REM_W-1:0]  rem;
  logic [DAYQ_W-1:0] dvd;
  logic [STEP_W-1:0] step;

  logic [REM_W-1:0]  divisor;
  logic [REM_W:0]    trial;
  logic [REM_W:0]    trial_diff;
  logic [REM_W-1:0]  rem_step;
  logic [TIME_W:0]   end_sum;

  logic [DAY_FOLD_PROD_W-1:0] fold_mid;
  logic [DAY_FOLD_PROD_W-1:0] fold_top;
  logic [DAYQ_W-1:0]          day_fold;
  logic [DAYQ_W-1:0]          day_red;

  // One restoring remainder step per cycle for the offset into the slot.
  always_comb begin
    divisor    = len_eff;
    trial      = {rem, dvd[DAYQ_W-1]};
    trial_diff = trial - {1'b0, divisor};
    rem_step   = (trial >= {1'b0, divisor}) ? trial_diff[REM_W-1:0] : trial[REM_W-1:0];
    end_sum    = {1'b0, slot_start} + (TIME_W + 1)'(len_eff);
  end

  // One fold of the day reduction per cycle; the last cycle also strips
  // the remaining multiples of 675.
  always_comb begin
    fold_mid = DAY_FOLD_PROD_W'(dvd[2*DAY_FOLD_W-1:DAY_FOLD_W]) *
               DAY_FOLD_PROD_W'(DAY_FOLD_MUL1);
    fold_top = DAY_FOLD_PROD_W'(dvd[DAYQ_W-1:2*DAY_FOLD_W]) *
               DAY_FOLD_PROD_W'(DAY_FOLD_MUL2);
    day_fold = DAYQ_W'(dvd[DAY_FOLD_W-1:0]) + DAYQ_W'(fold_mid) + DAYQ_W'(fold_top);
    if (day_fold >= DAYQ_W'(3 * DAY_ODD)) begin
      day_red = day_fold - DAYQ_W'(3 * DAY_ODD);
    end else if (day_fold >= DAYQ_W'(2 * DAY_ODD)) begin
      day_red = day_fold - DAYQ_W'(2 * DAY_ODD);
    end else if (day_fold >= DAYQ_W'(DAY_ODD)) begin
      day_red = day_fold - DAYQ_W'(DAY_ODD);
    end else begin
      day_red = day_fold;
    end
  end

  always_comb begin
    state_next = state;
    case (state)
      S_IDLE: begin
        if (push) begin
          state_next = (in_item.mode || tick_mode) ? S_SEND : S_DAY;
        end
      end
      S_DAY: begin
        if (step == STEP_W'(1)) begin
          state_next = S_SLOT;
        end
      end
      S_SLOT: begin
        if (step == STEP_W'(1)) begin
          state_next = S_START;
        end
      end
      S_START: state_next = S_END;
      S_END:   state_next = S_SEND;
      S_SEND: begin
        if (!q_full) begin
          state_next = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_ff @(posedge clk) begin
    case (state)
      S_IDLE: begin
        if (push) begin
          item <= in_item;
          dvd  <= in_item.t[TIME_W-1:DAY_SHIFT];
          rem  <= '0;
          step <= STEP_W'(DAY_FOLDS);
        end
      end
      S_DAY: begin
        if (step == STEP_W'(1)) begin
          // The day remainder and the low time bits form the time of day,
          // which is then reduced by the bar length.
          dvd  <= {day_red[DAY_REM_W-1:0], item.t[DAY_SHIFT-1:0],
                   (DAYQ_W - TOD_W)'(0)};
          rem  <= '0;
          step <= STEP_W'(TOD_W);
        end else begin
          dvd  <= day_fold;
          step <= step - 1'b1;
        end
      end
      S_SLOT: begin
        dvd  <= dvd << 1;
        rem  <= rem_step;
        step <= step - 1'b1;
      end
      S_START: begin
        // Slot start is the trade time less its offset into the slot.
        slot_start <= item.t - TIME_W'(rem);
      end
      S_END: begin
        slot_end <= end_sum[TIME_W] ? '1 : end_sum[TIME_W-1:0];
      end
      default: ;
    endcase
  end

  assign full             = (state != S_IDLE);
  assign q_push           = (state == S_SEND) && !q_full;
  assign q_item.trade     = item;
  assign q_item.slot_start = slot_start;
  assign q_item.slot_end  = slot_end;

  a_day_rem_bound: assert property (@(posedge clk) disable iff (rst)
    (state == S_DAY && step == STEP_W'(1)) |-> (day_red < DAYQ_W'(DAY_ODD)))
    else $error("day remainder out of range");

  a_slot_rem_bound: assert property (@(posedge clk) disable iff (rst)
    (state == S_SLOT || state == S_START) |-> (rem < len_eff))
    else $error("slot remainder not below the bar length");

endmodule

### src/ohlc_back.sv
module ohlc_back (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          q_empty,
  input  ohlc_pkg::work_t               q_item,
  output logic                          q_pop,
  input  logic                          out_full,
  output logic                          out_push,
  output ohlc_pkg::bar_t                out_bar,
  input  logic                          tick_mode,
  input  logic [ohlc_pkg::COUNT_W-1:0]  trade_limit
);

  import ohlc_pkg::*;

  logic                 active, active_next;
  logic [TIME_W-1:0]    bar_start, bar_start_next;
  logic [TIME_W-1:0]    bar_end, bar_end_next;
  logic [PRICE_W-1:0]   open_reg, open_reg_next;
  logic [PRICE_W-1:0]   high_reg, high_reg_next;
  logic [PRICE_W-1:0]   low_reg, low_reg_next;
  logic [PRICE_W-1:0]   close_reg, close_reg_next;
  logic [VOL_W-1:0]     volume_reg, volume_reg_next;
  logic [COUNT_W-1:0]   trade_count, trade_count_next;
  logic [SESSION_W-1:0] session_count, session_count_next;

  logic                 go;
  logic [TIME_W-1:0]    t;
  logic [PRICE_W-1:0]   p;
  logic                 has_price;
  logic                 done_old;
  logic                 fresh;
  logic                 emit_old;
  logic                 done_new;
  logic [TIME_W-1:0]    base_start;
  logic [TIME_W-1:0]    base_end;
  logic [PRICE_W-1:0]   base_open;
  logic [PRICE_W-1:0]   base_high;
  logic [PRICE_W-1:0]   base_low;
  logic [PRICE_W-1:0]   base_close;
  logic [VOL_W-1:0]     base_vol;
  logic [COUNT_W-1:0]   base_cnt;
  logic [VOL_W:0]       vol_sum;
  bar_t                 old_bar;
  bar_t                 new_bar;
  logic [SESSION_W-1:0] session_inc;

  always_comb begin
    go        = !q_empty && !out_full;
    t         = q_item.trade.t;
    p         = q_item.trade.price;
    has_price = (p != '0);

    session_inc = (session_count == '1) ? SESSION_W'(1) : session_count + 1'b1;

    old_bar.bar_time       = bar_start;
    old_bar.open_price     = open_reg;
    old_bar.high_price     = high_reg;
    old_bar.low_price      = low_reg;
    old_bar.close_price    = close_reg;
    old_bar.volume         = volume_reg;
    old_bar.tick_count     = trade_count;
    old_bar.session_number = session_count;

    // Does the live bar end before this trade joins it?
    done_old = active && (tick_mode ? (trade_count >= trade_limit) : (bar_end < t));
    fresh    = !active || done_old;
    emit_old = done_old && (low_reg != '0);

    base_open  = fresh ? '0 : open_reg;
    base_high  = fresh ? '0 : high_reg;
    base_low   = fresh ? '0 : low_reg;
    base_close = fresh ? '0 : close_reg;
    base_vol   = fresh ? '0 : volume_reg;
    base_cnt   = fresh ? '0 : trade_count;
    if (fresh) begin
      base_start = tick_mode ? t : q_item.slot_start;
      base_end   = tick_mode ? '0 : q_item.slot_end;
    end else begin
      base_start = bar_start;
      base_end   = bar_end;
    end

    new_bar.open_price  = (has_price && (base_open == '0)) ? p : base_open;
    new_bar.high_price  = (has_price && (p > base_high)) ? p : base_high;
    new_bar.low_price   = (has_price && ((base_low == '0) || (p < base_low))) ? p : base_low;
    new_bar.close_price = has_price ? p : base_close;
    vol_sum             = {1'b0, base_vol} + (VOL_W + 1)'(q_item.trade.qty);
    new_bar.volume      = vol_sum[VOL_W] ? '1 : vol_sum[VOL_W-1:0];
    new_bar.tick_count  = (base_cnt != '1) ? base_cnt + 1'b1 : base_cnt;
    new_bar.bar_time    = tick_mode ? t : base_start;
    new_bar.session_number = session_count;

    // A bar that just started may complete on this same trade, but only
    // if no earlier bar went out on it.
    done_new = !emit_old && (new_bar.low_price != '0) &&
               (tick_mode ? (new_bar.tick_count >= trade_limit) : (base_end == t));
  end

  always_comb begin
    active_next        = active;
    bar_start_next     = bar_start;
    bar_end_next       = bar_end;
    open_reg_next      = open_reg;
    high_reg_next      = high_reg;
    low_reg_next       = low_reg;
    close_reg_next     = close_reg;
    volume_reg_next    = volume_reg;
    trade_count_next   = trade_count;
    session_count_next = session_count;
    out_push           = 1'b0;
    out_bar            = old_bar;
    q_pop              = go;
    if (go) begin
      if (q_item.trade.mode) begin
        if (active && (low_reg != '0)) begin
          out_push    = 1'b1;
          active_next = 1'b0;
        end
        session_count_next = session_inc;
      end else begin
        active_next      = !done_new;
        bar_start_next   = new_bar.bar_time;
        bar_end_next     = base_end;
        open_reg_next    = new_bar.open_price;
        high_reg_next    = new_bar.high_price;
        low_reg_next     = new_bar.low_price;
        close_reg_next   = new_bar.close_price;
        volume_reg_next  = new_bar.volume;
        trade_count_next = new_bar.tick_count;
        out_push         = emit_old || done_new;
        out_bar          = emit_old ? old_bar : new_bar;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      active        <= 1'b0;
      bar_start     <= '0;
      bar_end       <= '0;
      open_reg      <= '0;
      high_reg      <= '0;
      low_reg       <= '0;
      close_reg     <= '0;
      volume_reg    <= '0;
      trade_count   <= '0;
      session_count <= SESSION_W'(1);
    end else begin
      active        <= active_next;
      bar_start     <= bar_start_next;
      bar_end       <= bar_end_next;
      open_reg      <= open_reg_next;
      high_reg      <= high_reg_next;
      low_reg       <= low_reg_next;
      close_reg     <= close_reg_next;
      volume_reg    <= volume_reg_next;
      trade_count   <= trade_count_next;
      session_count <= session_count_next;
    end
  end

  a_session_nonzero: assert property (@(posedge clk) disable iff (rst)
    session_count != '0)
    else $error("session counter reached zero");

  a_priced_bar_consistent: assert property (@(posedge clk) disable iff (rst)
    (low_reg != '0) |-> ((open_reg != '0) && (high_reg >= low_reg)))
    else $error("bar has a low price but no open or a high below it");

endmodule

### src/ohlc_bar_aggregator.sv
// Channel  | Handshake            | Fields of one beat
// ---------+----------------------+---------------------------------------------
// input    | push / full          | mode, time_seconds, price, qty
// result   | empty / pop          | bar_time, open_price, high_price, low_price,
//          |                      | close_price, volume, tick_count,
//          |                      | session_number
// config   | cfg_en (no wait)     | cfg_index, cfg_data
//
// A timed trade goes through the front end in turn: the accepting cycle, three folding
// steps that reduce the time modulo one day, 17 remainder steps for the offset
// into the bar slot, then the slot start, the slot end and queueing of the beat.
// Session events and tick-mode trades skip to queueing. The back end retires a beat
// per cycle while the result queue has room; a stalled result queue backs up into
// the work queue and then raises full. Reset clears the queues, the bar and config.
module ohlc_bar_aggregator #(
  parameter int WORK_QUEUE_DEPTH   = ohlc_pkg::WORK_QUEUE_DEPTH,
  parameter int RESULT_QUEUE_DEPTH = ohlc_pkg::RESULT_QUEUE_DEPTH
) (
  input  logic                              clk,
  input  logic                              rst,

  input  logic                              push,
  output logic                              full,
  input  logic                              mode,
  input  logic [ohlc_pkg::TIME_W-1:0]       time_seconds,
  input  logic [ohlc_pkg::PRICE_W-1:0]      price,
  input  logic [ohlc_pkg::QTY_W-1:0]        qty,

  output logic                              empty,
  input  logic                              pop,
  output logic [ohlc_pkg::TIME_W-1:0]       bar_time,
  output logic [ohlc_pkg::PRICE_W-1:0]      open_price,
  output logic [ohlc_pkg::PRICE_W-1:0]      high_price,
  output logic [ohlc_pkg::PRICE_W-1:0]      low_price,
  output logic [ohlc_pkg::PRICE_W-1:0]      close_price,
  output logic [ohlc_pkg::VOL_W-1:0]        volume,
  output logic [ohlc_pkg::COUNT_W-1:0]      tick_count,
  output logic [ohlc_pkg::SESSION_W-1:0]    session_number,

  input  logic                              cfg_en,
  input  logic [ohlc_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  logic [ohlc_pkg::CFG_DATA_W-1:0]   cfg_data
);

  import ohlc_pkg::*;

  // Configuration registers. The user must write them only while the block is
  // idle, which the block does not enforce, so that every unit may read them live.
  // Reset gives time mode, 60 second bars and 100 trades per tick bar.
  logic               tick_mode;
  logic [LEN_W-1:0]   bar_length_seconds;
  logic [COUNT_W-1:0] ticks_per_bar;

  // Clamped forms: bars shorter than five seconds run as five seconds, and
  // a trade limit of zero behaves as one.
  logic [LEN_W-1:0]   len_eff;
  logic [COUNT_W-1:0] trade_limit;

  trade_t in_item;
  work_t  fe_item;
  work_t  be_item;
  logic   fe_push;
  logic   wq_full;
  logic   wq_empty;
  logic   be_pop;
  logic   rq_full;
  logic   be_push;
  bar_t   be_bar;
  bar_t   head_bar;

  always_ff @(posedge clk) begin
    if (rst) begin
      tick_mode          <= 1'b0;
      bar_length_seconds <= RESET_BAR_SECONDS;
      ticks_per_bar      <= RESET_TICKS_PER_BAR;
    end else if (cfg_en) begin
      case (cfg_index)
        REG_TICK_MODE:     tick_mode          <= cfg_data[0];
        REG_BAR_LENGTH:    bar_length_seconds <= cfg_data[LEN_W-1:0];
        REG_TICKS_PER_BAR: ticks_per_bar      <= cfg_data[COUNT_W-1:0];
        default: ;
      endcase
    end
  end

  assign len_eff     = (bar_length_seconds < MIN_BAR_SECONDS) ? MIN_BAR_SECONDS
                                                               : bar_length_seconds;
  assign trade_limit = (ticks_per_bar == '0) ? COUNT_W'(1) : ticks_per_bar;

  always_comb begin
    in_item.mode  = mode;
    in_item.t     = time_seconds;
    in_item.price = price;
    in_item.qty   = qty;
  end

  // Front end: takes a beat and, for timed trades, works out the slot that
  // a new bar would cover.
  ohlc_front u_front (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .full      (full),
    .in_item   (in_item),
    .tick_mode (tick_mode),
    .len_eff   (len_eff),
    .q_push    (fe_push),
    .q_full    (wq_full),
    .q_item    (fe_item)
  );

  // Work queue between the slot calculation and the bar update.
  ohlc_fifo #(
    .WIDTH ($bits(work_t)),
    .DEPTH (WORK_QUEUE_DEPTH)
  ) u_work_q (
    .clk     (clk),
    .rst     (rst),
    .wr_en   (fe_push),
    .wr_data (fe_item),
    .full    (wq_full),
    .rd_en   (be_pop),
    .rd_data (be_item),
    .empty   (wq_empty)
  );

  // Back end: holds the running bar and decides when a bar goes out.
  ohlc_back u_back (
    .clk         (clk),
    .rst         (rst),
    .q_empty     (wq_empty),
    .q_item      (be_item),
    .q_pop       (be_pop),
    .out_full    (rq_full),
    .out_push    (be_push),
    .out_bar     (be_bar),
    .tick_mode   (tick_mode),
    .trade_limit (trade_limit)
  );

  // Result queue: finished bars wait here until the consumer pops them.
  ohlc_fifo #(
    .WIDTH ($bits(bar_t)),
    .DEPTH (RESULT_QUEUE_DEPTH)
  ) u_result_q (
    .clk     (clk),
    .rst     (rst),
    .wr_en   (be_push),
    .wr_data (be_bar),
    .full    (rq_full),
    .rd_en   (pop),
    .rd_data (head_bar),
    .empty   (empty)
  );

  assign bar_time       = head_bar.bar_time;
  assign open_price     = head_bar.open_price;
  assign high_price     = head_bar.high_price;
  assign low_price      = head_bar.low_price;
  assign close_price    = head_bar.close_price;
  assign volume         = head_bar.volume;
  assign tick_count     = head_bar.tick_count;
  assign session_number = head_bar.session_number;

endmodule
